// ===== rtl/x64_instruction_byte_encoder_macros.svh =====
// assertion helpers
`ifndef X64_INSTRUCTION_BYTE_ENCODER_MACROS_SVH
`define X64_INSTRUCTION_BYTE_ENCODER_MACROS_SVH
`define XE_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define XE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== rtl/xenc_pkg.sv =====
// ----------------------------------------------------------------------------
// xenc_pkg
// types and constants shared by the encoder front and back
// ----------------------------------------------------------------------------
package xenc_pkg;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int MAX_BYTES = 11;
    localparam int LEN_W = 4;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [MAX_BYTES-1:0]      site;
        logic [LEN_W-1:0]          len;
    } t_enc;
endpackage

// ===== rtl/x64_instruction_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// x64_instruction_byte_encoder
// encodes one request into x86-64 machine code bytes, one per output item
//
// channel  dir  handshake            payload
// in       in   i_valid / o_ready    action, fields, displacement, immediate
// out      out  o_valid / i_ready    code byte, offset, branch site, last
//
// one byte per cycle while i_ready is high; a request is 1 to 10 bytes long
// the back stage byte streamer sets the rate; the front builds the next item
// in parallel, with a two-entry queue between them
// reset clears the offset counter and all valid state
// undefined actions are dropped in the front
// ----------------------------------------------------------------------------
module x64_instruction_byte_encoder #(
    parameter int OFFSET_BITS = xenc_pkg::OFFSET_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [5:0]         i_action,
    input  logic [3:0]         i_reg_field,
    input  logic [3:0]         i_rm_reg,
    input  logic [3:0]         i_index_reg,
    input  logic signed [31:0] i_displacement,
    input  logic [63:0]        i_immediate,
    input  logic [3:0]         i_condition,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_code_byte,
    output logic [31:0]        o_byte_offset,
    output logic               o_branch_site,
    output logic               o_last
);
    logic f_valid, f_ready, q_valid, q_ready;
    xenc_pkg::t_enc f_enc, q_enc;

    xenc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_action, .i_reg_field, .i_rm_reg, .i_index_reg,
        .i_displacement, .i_immediate, .i_condition,
        .o_valid(f_valid), .i_ready(f_ready), .o_enc(f_enc)
    );

    xenc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_enc(f_enc),
        .o_valid(q_valid), .i_ready(q_ready), .o_enc(q_enc)
    );

    xenc_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_enc(q_enc),
        .o_valid, .i_ready,
        .o_code_byte, .o_byte_offset, .o_branch_site, .o_last
    );
endmodule

// ===== rtl/xenc_front.sv =====
// ----------------------------------------------------------------------------
// xenc_front
// builds the byte list of one request into a registered item
// ----------------------------------------------------------------------------
module xenc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [5:0]           i_action,
    input  logic [3:0]           i_reg_field,
    input  logic [3:0]           i_rm_reg,
    input  logic [3:0]           i_index_reg,
    input  logic signed [31:0]   i_displacement,
    input  logic [63:0]          i_immediate,
    input  logic [3:0]           i_condition,
    output logic                 o_valid,
    input  logic                 i_ready,
    output xenc_pkg::t_enc       o_enc
);
    logic           r_valid;
    xenc_pkg::t_enc r_enc;
    xenc_pkg::t_enc n_enc;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_enc   = r_enc;

    function automatic xenc_pkg::t_enc put(input xenc_pkg::t_enc e, input logic [7:0] b,
                                           input logic s);
        xenc_pkg::t_enc t;
        t = e;
        if (t.len < 4'(xenc_pkg::MAX_BYTES)) begin
            t.bytes[t.len] = b;
            t.site[t.len]  = s;
            t.len = t.len + 4'd1;
        end
        return t;
    endfunction

    function automatic xenc_pkg::t_enc put32(input xenc_pkg::t_enc e, input logic [31:0] v);
        xenc_pkg::t_enc t;
        t = put(e, v[7:0], 1'b0);
        t = put(t, v[15:8], 1'b0);
        t = put(t, v[23:16], 1'b0);
        t = put(t, v[31:24], 1'b0);
        return t;
    endfunction

    function automatic xenc_pkg::t_enc rex(input xenc_pkg::t_enc e, input logic w,
                                           input logic r, input logic x, input logic b);
        if (w | r | x | b) return put(e, {4'h4, w, r, x, b}, 1'b0);
        return e;
    endfunction

    logic [7:0] imm8;
    logic [31:0] disp, imm32;
    logic [1:0] md;
    logic [2:0] b3, g3;
    logic [3:0] ix;
    logic [7:0] op, ext;
    logic is_w;

    always_comb begin
        disp  = i_displacement;
        imm32 = i_immediate[31:0];
        imm8  = i_immediate[7:0];
        b3 = i_rm_reg[2:0];
        g3 = i_reg_field[2:0];
        ix = i_index_reg;
        if (disp == 32'd0 && b3 != 3'd5) md = 2'd0;
        else if ((disp + 32'd128) < 32'd256) md = 2'd1;
        else md = 2'd2;
        n_enc = '0;
        op = 8'h00;
        ext = 8'h00;
        is_w = 1'b0;
        case (i_action)
            6'd0, 6'd1: begin
                n_enc = rex(n_enc, i_action[0], 1'b0, 1'b0, i_rm_reg[3]);
                n_enc = put(n_enc, {5'b10111, b3}, 1'b0);
                n_enc = put32(n_enc, imm32);
                if (i_action[0]) n_enc = put32(n_enc, i_immediate[63:32]);
            end
            6'd2, 6'd3, 6'd4, 6'd5, 6'd7, 6'd8, 6'd9, 6'd10, 6'd14, 6'd31: begin
                case (i_action)
                    6'd2, 6'd3: op = 8'h89;
                    6'd4, 6'd14: op = 8'h01;
                    6'd5, 6'd31: op = 8'h29;
                    6'd7: op = 8'h21;
                    6'd8: op = 8'h09;
                    6'd9: op = 8'h31;
                    default: op = 8'h39;
                endcase
                is_w = (i_action == 6'd3) || (i_action == 6'd14) || (i_action == 6'd31);
                n_enc = rex(n_enc, is_w, i_reg_field[3], 1'b0, i_rm_reg[3]);
                n_enc = put(n_enc, op, 1'b0);
                n_enc = put(n_enc, {2'b11, g3, b3}, 1'b0);
            end
            6'd6: begin
                n_enc = rex(n_enc, 1'b0, i_reg_field[3], 1'b0, i_rm_reg[3]);
                n_enc = put(n_enc, 8'h0F, 1'b0);
                n_enc = put(n_enc, 8'hAF, 1'b0);
                n_enc = put(n_enc, {2'b11, g3, b3}, 1'b0);
            end
            6'd11, 6'd12, 6'd13, 6'd15, 6'd16, 6'd18, 6'd19, 6'd20, 6'd21,
            6'd22, 6'd23, 6'd24, 6'd52, 6'd54: begin
                case (i_action)
                    6'd11, 6'd15: begin op = 8'h81; ext = 8'd0; end
                    6'd12: begin op = 8'h81; ext = 8'd5; end
                    6'd13: begin op = 8'h81; ext = 8'd7; end
                    6'd16: begin op = 8'hF7; ext = 8'd3; end
                    6'd18: begin op = 8'hF7; ext = 8'd7; end
                    6'd19: begin op = 8'hD3; ext = 8'd4; end
                    6'd20: begin op = 8'hD3; ext = 8'd5; end
                    6'd21: begin op = 8'hD3; ext = 8'd7; end
                    6'd22: begin op = 8'hC1; ext = 8'd4; end
                    6'd23: begin op = 8'hC1; ext = 8'd5; end
                    6'd24: begin op = 8'hC1; ext = 8'd7; end
                    6'd52: begin op = 8'hFF; ext = 8'd2; end
                    default: begin op = 8'hFF; ext = 8'd4; end
                endcase
                n_enc = rex(n_enc, i_action == 6'd15, 1'b0, 1'b0, i_rm_reg[3]);
                n_enc = put(n_enc, op, 1'b0);
                n_enc = put(n_enc, {2'b11, ext[2:0], b3}, 1'b0);
                if (op == 8'h81) n_enc = put32(n_enc, imm32);
                if (op == 8'hC1) n_enc = put(n_enc, imm8, 1'b0);
            end
            6'd17: n_enc = put(n_enc, 8'h99, 1'b0);
            6'd25, 6'd26, 6'd27, 6'd28, 6'd32, 6'd33: begin
                if (i_action == 6'd32 || i_action == 6'd33) n_enc = put(n_enc, 8'hF3, 1'b0);
                n_enc = rex(n_enc, i_action == 6'd27 || i_action == 6'd28,
                            i_reg_field[3], 1'b0, i_rm_reg[3]);
                case (i_action)
                    6'd25, 6'd27: n_enc = put(n_enc, 8'h8B, 1'b0);
                    6'd26, 6'd28: n_enc = put(n_enc, 8'h89, 1'b0);
                    6'd32: begin
                        n_enc = put(n_enc, 8'h0F, 1'b0);
                        n_enc = put(n_enc, 8'h10, 1'b0);
                    end
                    default: begin
                        n_enc = put(n_enc, 8'h0F, 1'b0);
                        n_enc = put(n_enc, 8'h11, 1'b0);
                    end
                endcase
                n_enc = put(n_enc, {md, g3, b3}, 1'b0);
                if (b3 == 3'd4) n_enc = put(n_enc, 8'h24, 1'b0);
                if (md == 2'd1) n_enc = put(n_enc, disp[7:0], 1'b0);
                if (md == 2'd2) n_enc = put32(n_enc, disp);
            end
            6'd29, 6'd30: begin
                n_enc = rex(n_enc, 1'b0, i_reg_field[3], ix[3], i_rm_reg[3]);
                n_enc = put(n_enc, i_action[0] ? 8'h8B : 8'h89, 1'b0);
                n_enc = put(n_enc, {md, g3, 3'd4}, 1'b0);
                n_enc = put(n_enc, {2'b10, ix[2:0], b3}, 1'b0);
                if (md == 2'd1) n_enc = put(n_enc, disp[7:0], 1'b0);
                if (md == 2'd2) n_enc = put32(n_enc, disp);
            end
            6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41: begin
                case (i_action)
                    6'd34: op = 8'h58;
                    6'd35: op = 8'h5C;
                    6'd36: op = 8'h59;
                    6'd37: op = 8'h5E;
                    6'd38: op = 8'h2E;
                    6'd39: op = 8'h2C;
                    6'd40: op = 8'h2A;
                    default: op = 8'h6E;
                endcase
                if (i_action == 6'd41) n_enc = put(n_enc, 8'h66, 1'b0);
                else if (i_action != 6'd38) n_enc = put(n_enc, 8'hF3, 1'b0);
                n_enc = rex(n_enc, 1'b0, i_reg_field[3], 1'b0, i_rm_reg[3]);
                n_enc = put(n_enc, 8'h0F, 1'b0);
                n_enc = put(n_enc, op, 1'b0);
                n_enc = put(n_enc, {2'b11, g3, b3}, 1'b0);
            end
            6'd42: begin
                n_enc = put(n_enc, 8'h66, 1'b0);
                n_enc = rex(n_enc, 1'b0, i_reg_field[3], 1'b0, i_rm_reg[3]);
                n_enc = put(n_enc, 8'h0F, 1'b0);
                n_enc = put(n_enc, 8'h3A, 1'b0);
                n_enc = put(n_enc, 8'h0A, 1'b0);
                n_enc = put(n_enc, {2'b11, g3, b3}, 1'b0);
                n_enc = put(n_enc, imm8, 1'b0);
            end
            6'd43, 6'd44: begin
                n_enc = rex(n_enc, 1'b0, 1'b0, 1'b0, i_rm_reg[3]);
                n_enc = put(n_enc, {4'h5, ~i_action[0], b3}, 1'b0);
            end
            6'd45: n_enc = put(n_enc, 8'h90, 1'b0);
            6'd46: n_enc = put(n_enc, 8'hFC, 1'b0);
            6'd47: begin
                n_enc = put(n_enc, 8'hF3, 1'b0);
                n_enc = put(n_enc, 8'hA5, 1'b0);
            end
            6'd48: n_enc = put(n_enc, 8'hC3, 1'b0);
            6'd49, 6'd50, 6'd51, 6'd53: begin
                case (i_action)
                    6'd49: n_enc = put(n_enc, 8'hE9, 1'b0);
                    6'd51: n_enc = put(n_enc, 8'hE8, 1'b0);
                    6'd50: begin
                        n_enc = put(n_enc, 8'h0F, 1'b0);
                        n_enc = put(n_enc, {4'h8, i_condition}, 1'b0);
                    end
                    default: begin
                        n_enc = rex(n_enc, 1'b1, i_reg_field[3], 1'b0, 1'b0);
                        n_enc = put(n_enc, 8'h8D, 1'b0);
                        n_enc = put(n_enc, {2'b00, g3, 3'd5}, 1'b0);
                    end
                endcase
                n_enc = put(n_enc, 8'h00, 1'b1);
                n_enc = put(n_enc, 8'h00, 1'b0);
                n_enc = put(n_enc, 8'h00, 1'b0);
                n_enc = put(n_enc, 8'h00, 1'b0);
            end
            default: n_enc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && (n_enc.len != '0);
        end
        if (o_ready) r_enc <= n_enc;
    end
endmodule

// ===== rtl/xenc_queue.sv =====
// ----------------------------------------------------------------------------
// xenc_queue
// short queue of built items between front and back
// ----------------------------------------------------------------------------
module xenc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  xenc_pkg::t_enc i_enc,
    output logic           o_valid,
    input  logic           i_ready,
    output xenc_pkg::t_enc o_enc
);
    xenc_pkg::t_enc r_mem [xenc_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_enc   = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_enc;
    end
endmodule

// ===== rtl/xenc_back.sv =====
// ----------------------------------------------------------------------------
// xenc_back
// streams the bytes of one item with offsets and last flag
// ----------------------------------------------------------------------------
`include "x64_instruction_byte_encoder_macros.svh"
module xenc_back #(
    parameter int OFFSET_BITS = xenc_pkg::OFFSET_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  xenc_pkg::t_enc i_enc,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_code_byte,
    output logic [31:0]    o_byte_offset,
    output logic           o_branch_site,
    output logic           o_last
);
    logic [OFFSET_BITS-1:0] r_pos;
    logic [xenc_pkg::LEN_W-1:0] r_idx;
    logic [63:0] pos_ext;
    logic last_b;

    assign last_b = (r_idx + 4'd1) == i_enc.len;
    assign o_valid = i_valid;
    assign o_ready = i_ready && last_b;
    assign o_code_byte = i_enc.bytes[r_idx];
    assign o_branch_site = i_enc.site[r_idx];
    assign o_last = last_b;
    assign pos_ext = 64'(r_pos);
    assign o_byte_offset = pos_ext[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_idx <= '0;
        end else if (i_valid && i_ready) begin
            r_pos <= r_pos + 1'b1;
            r_idx <= last_b ? '0 : r_idx + 4'd1;
        end
    end

    `XE_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, i_valid, r_idx < i_enc.len)
    `XE_ASSERT_NEXT(a_idx_wrap, i_clk, i_rst_n, i_valid && i_ready && last_b, r_idx == '0)
    `XE_ASSERT_IMP(a_pop_last, i_clk, i_rst_n, o_ready && i_valid, o_last)
endmodule
